// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/gbn_pkg.sv =====
// ---------------------------------------------------------------------------
// gbn_pkg
// Word types, function and result codes and register indexes of the
// go-back-N endpoint.
// ---------------------------------------------------------------------------
package gbn_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'd1;

  localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd1000;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK = 2'd1;
  localparam logic [1:0] FUNC_DATA = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  localparam logic [2:0] KIND_SENT = 3'd0;
  localparam logic [2:0] KIND_WINDOW_FULL = 3'd1;
  localparam logic [2:0] KIND_TOO_LONG = 3'd2;
  localparam logic [2:0] KIND_ACK_TAKEN = 3'd3;
  localparam logic [2:0] KIND_ACK_IGNORED = 3'd4;
  localparam logic [2:0] KIND_RESENT = 3'd5;
  localparam logic [2:0] KIND_ACK_OUT = 3'd6;
  localparam logic [2:0] KIND_IDLE = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  seq_num;
    logic [31:0] payload_tag;
    logic [15:0] payload_len;
  } gbn_in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  seq_out;
    logic [31:0] tag_out;
    logic [15:0] len_out;
    logic        deliver;
    logic [3:0]  outstanding;
    logic        last_of_run;
  } gbn_out_t;

endpackage

// ===== rtl/go_back_n_endpoint_top.sv =====
// ---------------------------------------------------------------------------
// go_back_n_endpoint_top
// Go-Back-N endpoint: sender window with slot store, retransmit timer and
// in-order receiver, run by a small sequencer.
// ---------------------------------------------------------------------------
// channel   dir  handshake              payload
// command   in   start & !busy          cmd (gbn_in_t)
// result    out  result_stb, 1 cycle    result (gbn_out_t)
// config    in   cfg_we                 cfg_index, cfg_data
//
// An item is taken in the accept cycle, then handled in the execute cycle.
// A timeout tick resends every outstanding word from the slot store; the
// store's single registered read port yields one resent word per cycle.
// Results are registered; the receiver cannot stall.
// Reset is synchronous; the slot store is not cleared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module go_back_n_endpoint_top #(
  parameter int WINDOW_DEPTH = 8,
  parameter int SEQ_COUNT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  gbn_pkg::gbn_in_t                 cmd,
  output logic                             result_stb,
  output gbn_pkg::gbn_out_t                result,
  input  logic                             cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gbn_pkg::*;

  localparam int SEQ_W = $clog2(SEQ_COUNT);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_DW = 48;
  localparam logic [SEQ_W:0] SEQ_CNT_V = (SEQ_W + 1)'(SEQ_COUNT);
  localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_BURST = 3'b100
  } state_t;

  function automatic logic [SEQ_W-1:0] mod_seq(input logic [7:0] x);
    logic [11:0] r;
    r = {4'd0, x};
    for (int k = 3; k >= 0; k--) begin
      if (r >= 12'(SEQ_COUNT << k)) begin
        r = r - 12'(SEQ_COUNT << k);
      end
    end
    return r[SEQ_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] mod_win(input logic [SEQ_W-1:0] x);
    logic [14:0] r;
    r = 15'(x);
    for (int k = 7; k >= 0; k--) begin
      if (r >= 15'(WINDOW_DEPTH << k)) begin
        r = r - 15'(WINDOW_DEPTH << k);
      end
    end
    return r[SLOT_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_sub(input logic [SEQ_W-1:0] a,
                                              input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + SEQ_CNT_V - {1'b0, b};
    end
    return t[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] a);
    return (a == SEQ_LAST) ? '0 : a + 1'b1;
  endfunction

  state_t             state;
  gbn_in_t            in_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [SEQ_W-1:0]   send_base;
  logic [SEQ_W-1:0]   next_seq;
  logic [SEQ_W-1:0]   expected_seq;
  logic [31:0]        elapsed_ticks;
  logic [31:0]        timeout_ticks;
  logic [15:0]        max_payload;
  logic [SEQ_W-1:0]   cur_seq;
  logic [SLOT_W-1:0]  cur_slot;
  logic [CNT_W-1:0]   remaining;
  logic               pipe_vld;
  logic [SEQ_W-1:0]   pipe_seq;
  logic               pipe_last;
  logic [SLOT_DW-1:0] mem_q;
  logic               result_stb_r;
  gbn_out_t           result_r;

  logic [SLOT_DW-1:0] slot_mem [WINDOW_DEPTH];

  logic [SEQ_W-1:0]   count;
  logic [SEQ_W-1:0]   ack_d;
  logic               win_full;
  logic               too_long;
  logic               ack_ok;
  logic [31:0]        elapsed_inc;
  logic               timed_out;
  logic               send_ok;
  logic [SEQ_W-1:0]   next_seq_next;
  logic [SEQ_W-1:0]   expected_next;

  assign count         = seq_sub(next_seq, send_base);
  assign ack_d         = seq_sub(seq_r, send_base);
  assign win_full      = 32'(count) >= 32'(WINDOW_DEPTH);
  assign too_long      = in_r.payload_len > max_payload;
  assign ack_ok        = (ack_d != '0) && (ack_d <= count);
  assign elapsed_inc   = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 32'd1;
  assign timed_out     = elapsed_inc >= timeout_ticks;
  assign send_ok       = (in_r.func == FUNC_SEND) && !win_full && !too_long;
  assign next_seq_next = seq_inc(next_seq);
  assign expected_next = seq_inc(expected_seq);

  assign busy       = (state != ST_IDLE);
  assign result_stb = result_stb_r;
  assign result     = result_r;

  always_ff @(posedge clk) begin
    if ((state == ST_EXEC) && send_ok) begin
      slot_mem[mod_win(next_seq)] <= {in_r.payload_tag, in_r.payload_len};
    end
    mem_q <= slot_mem[cur_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      send_base     <= '0;
      next_seq      <= '0;
      expected_seq  <= '0;
      elapsed_ticks <= '0;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
      max_payload   <= MAX_PAYLOAD_RESET;
      remaining     <= '0;
      pipe_vld      <= 1'b0;
      result_stb_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          REG_MAX_PAYLOAD:   max_payload <= cfg_data[15:0];
          default: ;
        endcase
      end
      result_stb_r <= 1'b0;
      pipe_vld     <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            in_r  <= cmd;
            seq_r <= mod_seq(cmd.seq_num);
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state                <= ST_IDLE;
          result_stb_r         <= 1'b1;
          result_r.result_kind <= KIND_IDLE;
          result_r.seq_out     <= '0;
          result_r.tag_out     <= '0;
          result_r.len_out     <= '0;
          result_r.deliver     <= 1'b0;
          result_r.outstanding <= 4'(count);
          result_r.last_of_run <= 1'b1;
          case (in_r.func)
            FUNC_SEND: begin
              result_r.seq_out <= 8'(next_seq);
              if (win_full) begin
                result_r.result_kind <= KIND_WINDOW_FULL;
              end else if (too_long) begin
                result_r.result_kind <= KIND_TOO_LONG;
              end else begin
                if (count == '0) begin
                  elapsed_ticks <= '0;
                end
                next_seq             <= next_seq_next;
                result_r.result_kind <= KIND_SENT;
                result_r.tag_out     <= in_r.payload_tag;
                result_r.len_out     <= in_r.payload_len;
                result_r.outstanding <= 4'(seq_sub(next_seq_next, send_base));
              end
            end
            FUNC_ACK: begin
              result_r.seq_out <= 8'(seq_r);
              if (ack_ok) begin
                send_base            <= seq_r;
                elapsed_ticks        <= '0;
                result_r.result_kind <= KIND_ACK_TAKEN;
                result_r.outstanding <= 4'(count - ack_d);
              end else begin
                result_r.result_kind <= KIND_ACK_IGNORED;
              end
            end
            FUNC_DATA: begin
              result_r.result_kind <= KIND_ACK_OUT;
              if (seq_r == expected_seq) begin
                expected_seq     <= expected_next;
                result_r.seq_out <= 8'(expected_next);
                if (in_r.payload_len != '0) begin
                  result_r.deliver <= 1'b1;
                  result_r.tag_out <= in_r.payload_tag;
                  result_r.len_out <= in_r.payload_len;
                end
              end else begin
                result_r.seq_out <= 8'(expected_seq);
              end
            end
            default: begin
              if (count != '0) begin
                elapsed_ticks <= elapsed_inc;
                if (timed_out) begin
                  elapsed_ticks <= '0;
                  result_stb_r  <= 1'b0;
                  state         <= ST_BURST;
                  cur_seq       <= send_base;
                  cur_slot      <= mod_win(send_base);
                  remaining     <= CNT_W'(count);
                end
              end
            end
          endcase
        end
        ST_BURST: begin
          if (remaining != '0) begin
            pipe_vld  <= 1'b1;
            pipe_seq  <= cur_seq;
            pipe_last <= (remaining == CNT_W'(1));
            remaining <= remaining - 1'b1;
            cur_seq   <= seq_inc(cur_seq);
            if ((cur_seq == SEQ_LAST) || (cur_slot == SLOT_LAST)) begin
              cur_slot <= '0;
            end else begin
              cur_slot <= cur_slot + 1'b1;
            end
          end
          if (pipe_vld) begin
            result_stb_r         <= 1'b1;
            result_r.result_kind <= KIND_RESENT;
            result_r.seq_out     <= 8'(pipe_seq);
            result_r.tag_out     <= mem_q[47:16];
            result_r.len_out     <= mem_q[15:0];
            result_r.deliver     <= 1'b0;
            result_r.outstanding <= 4'(count);
            result_r.last_of_run <= pipe_last;
            if (pipe_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_window_bound, clk, rst, 32'(count) <= 32'(WINDOW_DEPTH), "window overrun")
  `ASSERT_NEXT(a_accept_exec, clk, rst, start && !busy, state == ST_EXEC, "accept lost")
  `ASSERT_ALWAYS(a_exec_quiet, clk, rst, !((state == ST_EXEC) && result_stb), "word in execute")
  `ASSERT_ALWAYS(a_idle_last, clk, rst, !((state == ST_IDLE) && result_stb && !result.last_of_run), "run not closed")

endmodule

// ===== sim/tb_go_back_n_endpoint_top.sv =====
// ---------------------------------------------------------------------------
// tb_go_back_n_endpoint_top
// Self-checking bench for the go-back-N endpoint. A directed table covers
// reset values, window full, length limit, ack range, timeout bursts and
// in-order, empty, duplicate and out-of-order data. Random phases follow,
// each under new register values. Typed rows are checked against fixed
// expected words, every other result word against an in-bench model.
// ---------------------------------------------------------------------------
module tb_go_back_n_endpoint_top;
  import gbn_pkg::*;

  localparam int WINDOW_DEPTH = 8;
  localparam int PHASE_WORDS = 30;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  gbn_in_t               cmd = '0;
  logic                  result_stb;
  gbn_out_t              result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  go_back_n_endpoint_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_stb(result_stb),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // endpoint model state
  logic [7:0]  tx_base = '0;
  logic [7:0]  tx_next = '0;
  logic [7:0]  rx_expected = '0;
  logic [31:0] tick_count = '0;
  logic [31:0] timeout_cfg = TIMEOUT_TICKS_RESET;
  logic [15:0] max_len_cfg = MAX_PAYLOAD_RESET;
  logic [31:0] held_tag [WINDOW_DEPTH];
  logic [15:0] held_len [WINDOW_DEPTH];

  gbn_out_t step_words[$];
  gbn_out_t due_words[$];
  int       err_count = 0;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
    gbn_in_t              word;
    bit                   typed;
    gbn_out_t             want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic logic [3:0] in_flight();
    logic [7:0] d;
    d = tx_next - tx_base;
    return d[3:0];
  endfunction

  function automatic void add_word(input logic [2:0] kind, input logic [7:0] seq,
                                   input logic [31:0] tag, input logic [15:0] len,
                                   input logic dlv);
    gbn_out_t w;
    w.result_kind = kind;
    w.seq_out = seq;
    w.tag_out = tag;
    w.len_out = len;
    w.deliver = dlv;
    w.outstanding = in_flight();
    w.last_of_run = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void endpoint_step(input gbn_in_t w);
    logic [7:0] d;
    logic [7:0] s;
    logic [3:0] cnt;
    gbn_out_t   tail;
    step_words.delete();
    case (w.func)
      FUNC_SEND: begin
        if (in_flight() >= WINDOW_DEPTH) begin
          add_word(KIND_WINDOW_FULL, tx_next, '0, '0, 1'b0);
        end else if (w.payload_len > max_len_cfg) begin
          add_word(KIND_TOO_LONG, tx_next, '0, '0, 1'b0);
        end else begin
          s = tx_next;
          held_tag[s % WINDOW_DEPTH] = w.payload_tag;
          held_len[s % WINDOW_DEPTH] = w.payload_len;
          if (tx_base == tx_next) tick_count = '0;
          tx_next = tx_next + 8'd1;
          add_word(KIND_SENT, s, w.payload_tag, w.payload_len, 1'b0);
        end
      end
      FUNC_ACK: begin
        d = w.seq_num - tx_base;
        if (d >= 8'd1 && d <= in_flight()) begin
          tx_base = w.seq_num;
          tick_count = '0;
          add_word(KIND_ACK_TAKEN, w.seq_num, '0, '0, 1'b0);
        end else begin
          add_word(KIND_ACK_IGNORED, w.seq_num, '0, '0, 1'b0);
        end
      end
      FUNC_DATA: begin
        if (w.seq_num == rx_expected) begin
          rx_expected = rx_expected + 8'd1;
          if (w.payload_len != 0)
            add_word(KIND_ACK_OUT, rx_expected, w.payload_tag, w.payload_len, 1'b1);
          else
            add_word(KIND_ACK_OUT, rx_expected, '0, '0, 1'b0);
        end else begin
          add_word(KIND_ACK_OUT, rx_expected, '0, '0, 1'b0);
        end
      end
      default: begin
        cnt = in_flight();
        if (cnt == 0) begin
          add_word(KIND_IDLE, '0, '0, '0, 1'b0);
        end else begin
          if (tick_count != 32'hFFFF_FFFF) tick_count = tick_count + 32'd1;
          if (tick_count >= timeout_cfg) begin
            for (int i = 0; i < cnt; i++) begin
              s = tx_base + i[7:0];
              add_word(KIND_RESENT, s, held_tag[s % WINDOW_DEPTH],
                       held_len[s % WINDOW_DEPTH], 1'b0);
            end
            tick_count = '0;
          end else begin
            add_word(KIND_IDLE, '0, '0, '0, 1'b0);
          end
        end
      end
    endcase
    tail = step_words.pop_back();
    tail.last_of_run = 1'b1;
    step_words.push_back(tail);
  endfunction

  function automatic gbn_in_t make_word(input logic [1:0] f, input logic [7:0] s,
                                        input logic [31:0] t, input logic [15:0] l);
    gbn_in_t w;
    w.func = f;
    w.seq_num = s;
    w.payload_tag = t;
    w.payload_len = l;
    return w;
  endfunction

  function automatic void add_cmd(input logic [1:0] f, input logic [7:0] s,
                                  input logic [31:0] t, input logic [15:0] l);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.word = make_word(f, s, t, l);
    r.typed = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  // single-word results whose values are plain from the state at that point
  function automatic void add_typed(input logic [1:0] f, input logic [7:0] s,
                                    input logic [31:0] t, input logic [15:0] l,
                                    input logic [2:0] kind, input logic [7:0] seq_o,
                                    input logic [31:0] tag_o, input logic [15:0] len_o,
                                    input logic [3:0] outst);
    plan_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.word = make_word(f, s, t, l);
    r.typed = 1'b1;
    r.want.result_kind = kind;
    r.want.seq_out = seq_o;
    r.want.tag_out = tag_o;
    r.want.len_out = len_o;
    r.want.deliver = 1'b0;
    r.want.outstanding = outst;
    r.want.last_of_run = 1'b1;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    plan_row_t r;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.word = '0;
    r.typed = 1'b0;
    r.want = '0;
    plan.push_back(r);
  endfunction

  function automatic gbn_in_t pick_word();
    gbn_in_t    w;
    int         r;
    logic [3:0] cnt;
    w.func = 2'($urandom);
    w.seq_num = 8'($urandom);
    w.payload_tag = $urandom;
    w.payload_len = 16'($urandom);
    cnt = in_flight();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      return w;
    end else if (r < 45) begin
      w.func = FUNC_SEND;
      case ($urandom_range(0, 9))
        0: w.payload_len = max_len_cfg + 16'd1;
        1: ;
        default: w.payload_len = 16'($urandom_range(0, max_len_cfg));
      endcase
    end else if (r < 65) begin
      w.func = FUNC_ACK;
      if (cnt != 0 && $urandom_range(0, 4) != 0)
        w.seq_num = tx_base + 8'($urandom_range(1, cnt));
    end else if (r < 85) begin
      w.func = FUNC_DATA;
      if ($urandom_range(0, 4) != 0) w.seq_num = rx_expected;
      if ($urandom_range(0, 4) == 0) w.payload_len = '0;
    end else begin
      w.func = FUNC_TICK;
    end
    return w;
  endfunction

  task automatic issue(input gbn_in_t w, input bit typed, input gbn_out_t want);
    start <= 1'b1;
    cmd <= w;
    do @(posedge clk); while (busy);
    endpoint_step(w);
    if (typed)
      due_words.push_back(want);
    else
      foreach (step_words[i]) due_words.push_back(step_words[i]);
  endtask

  task automatic idle_gap(input bit quiet);
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (due_words.size() != 0 || busy) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_TIMEOUT_TICKS) timeout_cfg = val;
    else if (idx == REG_MAX_PAYLOAD) max_len_cfg = val[15:0];
  endtask

  function automatic string fmt_word(input gbn_out_t w);
    return $sformatf("kind=%0d seq=%0d tag=%h len=%0d dlv=%0d out=%0d last=%0d",
                     w.result_kind, w.seq_out, w.tag_out, w.len_out, w.deliver,
                     w.outstanding, w.last_of_run);
  endfunction

  always @(posedge clk) begin
    gbn_out_t want;
    if (!rst && result_stb) begin
      if (due_words.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected word: %s", fmt_word(result));
      end else begin
        want = due_words.pop_front();
        if (result.result_kind !== want.result_kind || result.seq_out !== want.seq_out ||
            result.tag_out !== want.tag_out || result.len_out !== want.len_out ||
            result.deliver !== want.deliver || result.outstanding !== want.outstanding ||
            result.last_of_run !== want.last_of_run) begin
          err_count++;
          if (err_count <= 10)
            $display("word mismatch: expected %s / got %s", fmt_word(want),
                     fmt_word(result));
        end
      end
    end
  end

  initial begin
    gbn_in_t  w;
    gbn_out_t none;
    none = '0;

    // reset values of both registers apply here
    add_typed(FUNC_TICK, 8'd0, 32'd0, 16'd0, KIND_IDLE, 8'd0, 32'd0, 16'd0, 4'd0);
    add_typed(FUNC_ACK, 8'd0, 32'd0, 16'd0, KIND_ACK_IGNORED, 8'd0, 32'd0, 16'd0, 4'd0);
    add_typed(FUNC_SEND, 8'd0, 32'h5A5A_5A5A, 16'd1025,
              KIND_TOO_LONG, 8'd0, 32'd0, 16'd0, 4'd0);
    add_typed(FUNC_SEND, 8'hFF, 32'hFFFF_FFFF, 16'd1024,
              KIND_SENT, 8'd0, 32'hFFFF_FFFF, 16'd1024, 4'd1);
    add_typed(FUNC_SEND, 8'd0, 32'd0, 16'd0, KIND_SENT, 8'd1, 32'd0, 16'd0, 4'd2);
    add_cmd(FUNC_SEND, 8'd0, 32'h1234_5678, 16'd1);
    add_cmd(FUNC_SEND, 8'd0, 32'h8000_0001, 16'd512);
    add_cmd(FUNC_SEND, 8'd0, 32'hDEAD_BEEF, 16'd100);
    add_cmd(FUNC_SEND, 8'd0, 32'h0F0F_0F0F, 16'd1023);
    add_cmd(FUNC_SEND, 8'd0, 32'hC001_D00D, 16'd7);
    add_cmd(FUNC_SEND, 8'd0, 32'h7FFF_FFFF, 16'd300);
    // window full wins over an oversize length
    add_typed(FUNC_SEND, 8'd0, 32'd1, 16'hFFFF, KIND_WINDOW_FULL, 8'd8, 32'd0, 16'd0, 4'd8);
    add_cmd(FUNC_TICK, 8'd0, 32'd0, 16'd0);
    add_reg(REG_TIMEOUT_TICKS, 32'd0);
    add_cmd(FUNC_TICK, 8'd0, 32'd0, 16'd0);
    add_cmd(FUNC_ACK, 8'd255, 32'd0, 16'd0);
    add_cmd(FUNC_ACK, 8'd3, 32'd0, 16'd0);
    add_cmd(FUNC_ACK, 8'd8, 32'd0, 16'd0);
    add_cmd(FUNC_TICK, 8'd0, 32'd0, 16'd0);
    add_typed(FUNC_DATA, 8'd0, 32'h1111_1111, 16'd0, KIND_ACK_OUT, 8'd1, 32'd0, 16'd0, 4'd0);
    add_cmd(FUNC_DATA, 8'd7, 32'h2222_2222, 16'd5);
    add_cmd(FUNC_DATA, 8'd1, 32'hFFFF_FFFF, 16'hFFFF);
    add_cmd(FUNC_DATA, 8'd1, 32'h3333_3333, 16'd9);
    add_reg(REG_MAX_PAYLOAD, 32'd0);
    add_reg(REG_TIMEOUT_TICKS, 32'd2);
    add_cmd(FUNC_SEND, 8'd0, 32'hAAAA_AAAA, 16'd0);
    add_cmd(FUNC_SEND, 8'd0, 32'h5555_5555, 16'd1);
    add_cmd(FUNC_TICK, 8'd0, 32'd0, 16'd0);
    add_cmd(FUNC_TICK, 8'd0, 32'd0, 16'd0);
    add_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
    add_reg(REG_MAX_PAYLOAD, 32'h0000_FFFF);
    add_cmd(FUNC_SEND, 8'd0, 32'd0, 16'hFFFF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue(plan[i].word, plan[i].typed, plan[i].want);
        idle_gap(1'b0);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_TIMEOUT_TICKS, 32'd1);
          write_reg(REG_MAX_PAYLOAD, 32'h0000_FFFF);
        end
        1: begin
          write_reg(REG_TIMEOUT_TICKS, $urandom_range(2, 5));
          write_reg(REG_MAX_PAYLOAD, $urandom_range(0, 2000));
        end
        2: begin
          write_reg(REG_TIMEOUT_TICKS, 32'd0);
          write_reg(REG_MAX_PAYLOAD, $urandom_range(0, 65535));
        end
        3: begin
          write_reg(REG_TIMEOUT_TICKS, 32'd3);
          write_reg(REG_MAX_PAYLOAD, 32'(MAX_PAYLOAD_RESET));
        end
        4: begin
          write_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
          write_reg(REG_MAX_PAYLOAD, 32'h0000_FFFF);
        end
        default: begin
          write_reg(REG_TIMEOUT_TICKS, $urandom_range(1, 8));
          write_reg(REG_MAX_PAYLOAD, $urandom_range(0, 65535));
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        w = pick_word();
        issue(w, 1'b0, none);
        // phase 3 runs back to back
        idle_gap(ph == 3);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (due_words.size() != 0) err_count++;
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
